[rtl/pssc_pkg.sv]
// ----------------------------------------------------------------------------
// pssc_pkg
// Shared types, defaults and the edge selection table for the plane slice
// segment crossings block.
// ----------------------------------------------------------------------------
`default_nettype none

package pssc_pkg;

    localparam int SEGMENT_DEPTH_DEF = 64;
    localparam int COORD_WIDTH_DEF   = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_E1,
        S_E1W,
        S_E2,
        S_E2W,
        S_RD,
        S_DIFF,
        S_MUL,
        S_DEN,
        S_CMP,
        S_DIV,
        S_PUSH,
        S_STORE,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic       new_mesh;
        logic [2:0] below;
    } t_tri_ctl;

    typedef struct packed {
        logic [1:0] n0;
        logic [1:0] p0;
        logic [1:0] n1;
        logic [1:0] p1;
    } t_edges;

    // (below vertex, other vertex) of both crossed edges per below mask
    function automatic t_edges edge_sel(input logic [2:0] below);
        t_edges e;
        case (below)
            3'd1:    e = '{2'd0, 2'd1, 2'd0, 2'd2};
            3'd2:    e = '{2'd1, 2'd0, 2'd1, 2'd2};
            3'd3:    e = '{2'd0, 2'd2, 2'd1, 2'd2};
            3'd4:    e = '{2'd2, 2'd0, 2'd2, 2'd1};
            3'd5:    e = '{2'd0, 2'd1, 2'd2, 2'd1};
            3'd6:    e = '{2'd1, 2'd0, 2'd2, 2'd0};
            default: e = '{2'd0, 2'd0, 2'd0, 2'd0};
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

[rtl/pssc_ram.sv]
// ----------------------------------------------------------------------------
// pssc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pssc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/pssc_muldiv.sv]
// ----------------------------------------------------------------------------
// pssc_muldiv
// Bit-serial floor(a * b / d) for 0 <= b <= d, d > 0, on two multiplicands
// sharing b and d. Each bit of a, MSB first, takes a shift phase then an add phase.
// ----------------------------------------------------------------------------
`default_nettype none

module pssc_muldiv #(
    parameter int AW = 33,
    parameter int DW = 66
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [AW-1:0] i_a_x,
    input  wire logic [AW-1:0] i_a_y,
    input  wire logic [DW-1:0] i_b,
    input  wire logic [DW-1:0] i_d,
    output      logic          o_done,
    output      logic [AW-1:0] o_q_x,
    output      logic [AW-1:0] o_q_y
);

    localparam int BW = $clog2(AW);

    logic          r_busy, r_phase, r_done;
    logic [BW-1:0] r_bit;
    logic [AW-1:0] r_a_x, r_a_y, r_q_x, r_q_y, n_q_x, n_q_y;
    logic [DW-1:0] r_b, r_d, r_rem_x, r_rem_y, n_rem_x, n_rem_y;

    function automatic logic [DW+AW-1:0] step(
        input logic          phase,
        input logic          abit,
        input logic [DW-1:0] rem,
        input logic [AW-1:0] q,
        input logic [DW-1:0] b,
        input logic [DW-1:0] d
    );
        logic [DW:0]   s;
        logic          ge;
        logic [DW-1:0] nr;
        logic [AW-1:0] nq;
        if (!phase) begin
            s  = {rem, 1'b0};
            ge = s >= {1'b0, d};
            nr = ge ? DW'(s - {1'b0, d}) : s[DW-1:0];
            nq = {q[AW-2:0], ge};
        end else begin
            s  = {1'b0, rem} + {1'b0, b};
            ge = abit && (s >= {1'b0, d});
            nr = abit ? (ge ? DW'(s - {1'b0, d}) : s[DW-1:0]) : rem;
            nq = ge ? AW'(q + 1'b1) : q;
        end
        return {nr, nq};
    endfunction

    always_comb begin
        {n_rem_x, n_q_x} = step(r_phase, r_a_x[r_bit], r_rem_x, r_q_x, r_b, r_d);
        {n_rem_y, n_q_y} = step(r_phase, r_a_y[r_bit], r_rem_y, r_q_y, r_b, r_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_done  <= 1'b0;
            r_bit   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_bit   <= BW'(AW - 1);
            end else if (r_busy) begin
                r_phase <= !r_phase;
                if (r_phase) begin
                    if (r_bit == '0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_bit <= r_bit - 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a_x   <= i_a_x;
            r_a_y   <= i_a_y;
            r_b     <= i_b;
            r_d     <= i_d;
            r_rem_x <= '0;
            r_rem_y <= '0;
            r_q_x   <= '0;
            r_q_y   <= '0;
        end else if (r_busy) begin
            r_rem_x <= n_rem_x;
            r_rem_y <= n_rem_y;
            r_q_x   <= n_q_x;
            r_q_y   <= n_q_y;
        end
    end

    assign o_done = r_done;
    assign o_q_x  = r_q_x;
    assign o_q_y  = r_q_y;

endmodule

`default_nettype wire

[rtl/pssc_front.sv]
// ----------------------------------------------------------------------------
// pssc_front
// Holds the plane height, takes triangles, works out vertex heights above the
// plane and the below mask, and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pssc_front import pssc_pkg::*; #(
    parameter int CW = COORD_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  push,
    output      logic                  full,
    input  wire logic                  i_new_mesh,
    input  wire logic [2:0][CW-1:0]    i_x,
    input  wire logic [2:0][CW-1:0]    i_y,
    input  wire logic [2:0][CW-1:0]    i_z,
    input  wire logic                  i_cfg_we,
    input  wire logic [CW-1:0]         i_cfg_wdata,
    output      logic                  o_valid,
    input  wire logic                  i_ready,
    output      t_tri_ctl              o_ctl,
    output      logic [2:0][CW-1:0]    o_x,
    output      logic [2:0][CW-1:0]    o_y,
    output      logic [2:0][CW:0]      o_dz
);

    localparam int QD = 2;

    logic [CW-1:0]         r_plane_height;
    logic [2:0][CW:0]      c_dz;
    t_tri_ctl              c_ctl;
    t_tri_ctl              r_q_ctl [QD];
    logic [2:0][CW-1:0]    r_q_x   [QD];
    logic [2:0][CW-1:0]    r_q_y   [QD];
    logic [2:0][CW:0]      r_q_dz  [QD];
    logic                  r_wp, r_rp;
    logic [1:0]            r_cnt;
    logic                  w_push, w_pop;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_dz[i] = {i_z[i][CW-1], i_z[i]} - {r_plane_height[CW-1], r_plane_height};
            c_ctl.below[i] = c_dz[i][CW];
        end
        c_ctl.new_mesh = i_new_mesh;
    end

    assign full    = (r_cnt == 2'(QD));
    assign o_valid = (r_cnt != '0);
    assign w_push  = push && !full;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_height <= '0;
            r_wp           <= 1'b0;
            r_rp           <= 1'b0;
            r_cnt          <= '0;
        end else begin
            if (i_cfg_we) begin
                r_plane_height <= i_cfg_wdata;
            end
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_ctl[r_wp] <= c_ctl;
            r_q_x[r_wp]   <= i_x;
            r_q_y[r_wp]   <= i_y;
            r_q_dz[r_wp]  <= c_dz;
        end
    end

    assign o_ctl = r_q_ctl[r_rp];
    assign o_x   = r_q_x[r_rp];
    assign o_y   = r_q_y[r_rp];
    assign o_dz  = r_q_dz[r_rp];

endmodule

`default_nettype wire

[rtl/pssc_back.sv]
// ----------------------------------------------------------------------------
// pssc_back
// Sequencer: interpolates the slice segment, walks the segment store testing
// each pair, stores the segment and queues crossing points.
// ----------------------------------------------------------------------------
`default_nettype none

module pssc_back import pssc_pkg::*; #(
    parameter int CW    = COORD_WIDTH_DEF,
    parameter int DEPTH = SEGMENT_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output      logic                  o_ready,
    input  wire t_tri_ctl              i_ctl,
    input  wire logic [2:0][CW-1:0]    i_x,
    input  wire logic [2:0][CW-1:0]    i_y,
    input  wire logic [2:0][CW:0]      i_dz,
    output      logic                  empty,
    input  wire logic                  pop,
    output      logic [CW-1:0]         o_cross_x,
    output      logic [CW-1:0]         o_cross_y,
    output      logic                  o_last_of_run,
    output      logic                  o_store_full
);

    localparam int DZW  = CW + 1;
    localparam int AW   = CW + 1;
    localparam int DW   = 2 * CW + 2;
    localparam int PW   = 2 * CW + 3;
    localparam int IW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int MW   = 4 * CW;
    localparam int OD   = 2;

    t_state r_state, n_state;

    t_tri_ctl              r_ctl;
    logic [2:0][CW-1:0]    r_x, r_y;
    logic [2:0][DZW-1:0]   r_dz;
    logic [CNTW-1:0]       r_count;
    logic                  r_ovf;
    logic [IW-1:0]         r_idx;
    logic [CW-1:0]         r_p1x, r_p1y, r_p2x, r_p2y;
    logic signed [DZW-1:0] r_rx, r_ry, r_ux, r_uy, r_wx, r_wy;
    logic signed [DW-1:0]  r_m0, r_m1, r_m2, r_m3, r_m4, r_m5;
    logic signed [PW-1:0]  r_den, r_sn, r_tn;
    logic                  r_pend_v;
    logic [CW-1:0]         r_pend_x, r_pend_y, r_new_x, r_new_y;

    logic [CW-1:0]         r_of_x    [OD];
    logic [CW-1:0]         r_of_y    [OD];
    logic                  r_of_last [OD];
    logic                  r_of_full [OD];
    logic                  r_of_wp, r_of_rp;
    logic [1:0]            r_of_cnt;

    t_edges                c_ev;
    logic                  c_second, c_straddle, c_last, c_shared, c_ok, c_of_full;
    logic [1:0]            c_en, c_ep;
    logic [CW-1:0]         c_xn, c_xp, c_yn, c_yp;
    logic [DZW-1:0]        c_dzn, c_dzp, c_dx, c_dy, c_eb;
    logic [DZW:0]          c_ed;
    logic [CW-1:0]         c_pt_x, c_pt_y;
    logic [CW-1:0]         c_q1x, c_q1y, c_q2x, c_q2y;
    logic signed [PW-1:0]  c_den, c_sn, c_tn;

    logic                  md_start, md_done;
    logic [AW-1:0]         md_a_x, md_a_y, md_q_x, md_q_y;
    logic [DW-1:0]         md_b, md_d;
    logic                  ram_we, of_push, of_last;
    logic [MW-1:0]         ram_rdata;

    function automatic logic [CW-1:0] pick(input logic [2:0][CW-1:0] v, input logic [1:0] k);
        case (k)
            2'd1:    return v[1];
            2'd2:    return v[2];
            default: return v[0];
        endcase
    endfunction

    function automatic logic [DZW-1:0] pick_dz(input logic [2:0][DZW-1:0] v,
                                               input logic [1:0] k);
        case (k)
            2'd1:    return v[1];
            2'd2:    return v[2];
            default: return v[0];
        endcase
    endfunction

    function automatic logic [AW-1:0] mag(input logic [DZW-1:0] v);
        return v[DZW-1] ? AW'(~v + 1'b1) : AW'(v);
    endfunction

    function automatic logic [CW-1:0] offs(input logic [CW-1:0] base, input logic neg,
                                           input logic [AW-1:0] q);
        logic [CW+1:0] t;
        logic [CW+1:0] s;
        t = {1'b0, q};
        s = {{2{base[CW-1]}}, base} + (neg ? (~t + 1'b1) : t);
        return s[CW-1:0];
    endfunction

    function automatic logic [DZW-1:0] sub(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return {a[CW-1], a} - {b[CW-1], b};
    endfunction

    // edge operands
    always_comb begin
        c_ev     = edge_sel(r_ctl.below);
        c_second = (r_state == S_E2) || (r_state == S_E2W);
        c_en     = c_second ? c_ev.n1 : c_ev.n0;
        c_ep     = c_second ? c_ev.p1 : c_ev.p0;
        c_xn     = pick(r_x, c_en);
        c_xp     = pick(r_x, c_ep);
        c_yn     = pick(r_y, c_en);
        c_yp     = pick(r_y, c_ep);
        c_dzn    = pick_dz(r_dz, c_en);
        c_dzp    = pick_dz(r_dz, c_ep);
        c_dx     = sub(c_xp, c_xn);
        c_dy     = sub(c_yp, c_yn);
        c_eb     = ~c_dzn + 1'b1;
        c_ed     = {c_dzp[DZW-1], c_dzp} - {c_dzn[DZW-1], c_dzn};
    end

    // pair test terms
    always_comb begin
        {c_q1x, c_q1y, c_q2x, c_q2y} = ram_rdata;
        c_shared = ({r_p1x, r_p1y} == {c_q1x, c_q1y}) || ({r_p1x, r_p1y} == {c_q2x, c_q2y})
                || ({r_p2x, r_p2y} == {c_q1x, c_q1y}) || ({r_p2x, r_p2y} == {c_q2x, c_q2y});
        c_den = {r_m0[DW-1], r_m0} - {r_m1[DW-1], r_m1};
        c_sn  = {r_m2[DW-1], r_m2} - {r_m3[DW-1], r_m3};
        c_tn  = {r_m4[DW-1], r_m4} - {r_m5[DW-1], r_m5};
        c_ok  = (r_den != '0) && !r_sn[PW-1] && (r_sn <= r_den)
             && !r_tn[PW-1] && (r_tn <= r_den);
        c_straddle = (i_ctl.below != 3'b000) && (i_ctl.below != 3'b111);
        c_last     = (CNTW'(r_idx) + 1'b1) == r_count;
        c_of_full  = (r_of_cnt == 2'(OD));
    end

    // muldiv operands and results
    always_comb begin
        if (r_state == S_CMP) begin
            md_a_x = mag(r_rx);
            md_a_y = mag(r_ry);
            md_b   = r_tn[DW-1:0];
            md_d   = r_den[DW-1:0];
        end else begin
            md_a_x = mag(c_dx);
            md_a_y = mag(c_dy);
            md_b   = {{(DW-DZW){1'b0}}, c_eb};
            md_d   = {{(DW-DZW-1){1'b0}}, c_ed};
        end
        if (r_state == S_DIV) begin
            c_pt_x = offs(r_p1x, r_rx[DZW-1], md_q_x);
            c_pt_y = offs(r_p1y, r_ry[DZW-1], md_q_y);
        end else begin
            c_pt_x = offs(c_xn, c_dx[DZW-1], md_q_x);
            c_pt_y = offs(c_yn, c_dy[DZW-1], md_q_y);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid && c_straddle) n_state = S_E1;
            S_E1:    n_state = S_E1W;
            S_E1W:   if (md_done) n_state = S_E2;
            S_E2:    n_state = S_E2W;
            S_E2W:   if (md_done) n_state = (r_count == '0) ? S_STORE : S_RD;
            S_RD:    n_state = S_DIFF;
            S_DIFF:  if (c_shared) n_state = c_last ? S_STORE : S_RD;
                     else n_state = S_MUL;
            S_MUL:   n_state = S_DEN;
            S_DEN:   n_state = S_CMP;
            S_CMP:   if (c_ok) n_state = S_DIV;
                     else n_state = c_last ? S_STORE : S_RD;
            S_DIV:   if (md_done) n_state = S_PUSH;
            S_PUSH:  if (!r_pend_v || !c_of_full) n_state = c_last ? S_STORE : S_RD;
            S_STORE: n_state = r_pend_v ? S_FLUSH : S_IDLE;
            S_FLUSH: if (!c_of_full) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_ready  = (r_state == S_IDLE);
        md_start = (r_state == S_E1) || (r_state == S_E2) || ((r_state == S_CMP) && c_ok);
        ram_we   = (r_state == S_STORE) && (r_count != CNTW'(DEPTH));
        of_push  = ((r_state == S_PUSH) && r_pend_v && !c_of_full)
                || ((r_state == S_FLUSH) && !c_of_full);
        of_last  = (r_state == S_FLUSH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_pend_v <= 1'b0;
            r_idx    <= '0;
            r_of_wp  <= 1'b0;
            r_of_rp  <= 1'b0;
            r_of_cnt <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_IDLE) && i_valid) begin
                if (i_ctl.new_mesh) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_ovf <= r_ovf || (c_straddle && (r_count == CNTW'(DEPTH)));
                end
            end
            if (ram_we) begin
                r_count <= r_count + 1'b1;
            end
            if (r_state == S_E2W) begin
                r_idx <= '0;
            end else if (r_state != S_RD && n_state == S_RD) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_state == S_PUSH && n_state != S_PUSH) begin
                r_pend_v <= 1'b1;
            end else if (r_state == S_FLUSH && n_state == S_IDLE) begin
                r_pend_v <= 1'b0;
            end
            if (of_push) begin
                r_of_wp <= !r_of_wp;
            end
            if (pop && !empty) begin
                r_of_rp <= !r_of_rp;
            end
            r_of_cnt <= r_of_cnt + 2'(of_push) - 2'(pop && !empty);
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_valid) begin
            r_ctl <= i_ctl;
            r_x   <= i_x;
            r_y   <= i_y;
            r_dz  <= i_dz;
        end
        if ((r_state == S_E1W) && md_done) begin
            r_p1x <= c_pt_x;
            r_p1y <= c_pt_y;
        end
        if ((r_state == S_E2W) && md_done) begin
            r_p2x <= c_pt_x;
            r_p2y <= c_pt_y;
            r_rx  <= sub(c_pt_x, r_p1x);
            r_ry  <= sub(c_pt_y, r_p1y);
        end
        if (r_state == S_DIFF) begin
            r_ux <= sub(c_q2x, c_q1x);
            r_uy <= sub(c_q2y, c_q1y);
            r_wx <= sub(r_p1x, c_q1x);
            r_wy <= sub(r_p1y, c_q1y);
        end
        if (r_state == S_MUL) begin
            r_m0 <= r_rx * r_uy;
            r_m1 <= r_ry * r_ux;
            r_m2 <= r_rx * r_wy;
            r_m3 <= r_ry * r_wx;
            r_m4 <= r_ux * r_wy;
            r_m5 <= r_uy * r_wx;
        end
        if (r_state == S_DEN) begin
            if (c_den[PW-1]) begin
                r_den <= -c_den;
                r_sn  <= -c_sn;
                r_tn  <= -c_tn;
            end else begin
                r_den <= c_den;
                r_sn  <= c_sn;
                r_tn  <= c_tn;
            end
        end
        if ((r_state == S_DIV) && md_done) begin
            r_new_x <= c_pt_x;
            r_new_y <= c_pt_y;
        end
        if (r_state == S_PUSH && n_state != S_PUSH) begin
            r_pend_x <= r_new_x;
            r_pend_y <= r_new_y;
        end
        if (of_push) begin
            r_of_x[r_of_wp]    <= r_pend_x;
            r_of_y[r_of_wp]    <= r_pend_y;
            r_of_last[r_of_wp] <= of_last;
            r_of_full[r_of_wp] <= r_ovf;
        end
    end

    pssc_muldiv #(
        .AW (AW),
        .DW (DW)
    ) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (md_start),
        .i_a_x   (md_a_x),
        .i_a_y   (md_a_y),
        .i_b     (md_b),
        .i_d     (md_d),
        .o_done  (md_done),
        .o_q_x   (md_q_x),
        .o_q_y   (md_q_y)
    );

    pssc_ram #(
        .WIDTH (MW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata ({r_p1x, r_p1y, r_p2x, r_p2y}),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign empty         = (r_of_cnt == '0);
    assign o_cross_x     = r_of_x[r_of_rp];
    assign o_cross_y     = r_of_y[r_of_rp];
    assign o_last_of_run = r_of_last[r_of_rp];
    assign o_store_full  = r_of_full[r_of_rp];

endmodule

`default_nettype wire

[rtl/plane_slice_segment_crossings_unit.sv]
// A triangle that misses the plane is accepted and dropped by the back end; one that
// straddles it runs both edge interpolations on the bit-serial divider, tests each
// stored segment against the new one, divides for each crossing found, then stores the
// segment and flushes the last crossing, stalling while the result queue is full.
// Throughput is set by the single back-end sequencer and its bit-serial divider.
// Synchronous active-low reset clears the store count, the full flag and both queues.
// ----------------------------------------------------------------------------
// plane_slice_segment_crossings_unit
// Slices triangles with a horizontal plane and reports where each new slice
// segment crosses the segments stored so far.
// ----------------------------------------------------------------------------
`default_nettype none

module plane_slice_segment_crossings_unit import pssc_pkg::*; #(
    parameter int SEGMENT_DEPTH = SEGMENT_DEPTH_DEF,
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [COORD_WIDTH-1:0] i_cfg_wdata,
    input  wire logic                   push,
    output      logic                   full,
    input  wire logic                   i_new_mesh,
    input  wire logic [COORD_WIDTH-1:0] i_vertex_a_x,
    input  wire logic [COORD_WIDTH-1:0] i_vertex_a_y,
    input  wire logic [COORD_WIDTH-1:0] i_vertex_a_z,
    input  wire logic [COORD_WIDTH-1:0] i_vertex_b_x,
    input  wire logic [COORD_WIDTH-1:0] i_vertex_b_y,
    input  wire logic [COORD_WIDTH-1:0] i_vertex_b_z,
    input  wire logic [COORD_WIDTH-1:0] i_vertex_c_x,
    input  wire logic [COORD_WIDTH-1:0] i_vertex_c_y,
    input  wire logic [COORD_WIDTH-1:0] i_vertex_c_z,
    output      logic                   empty,
    input  wire logic                   pop,
    output      logic [COORD_WIDTH-1:0] o_cross_x,
    output      logic [COORD_WIDTH-1:0] o_cross_y,
    output      logic                   o_last_of_run,
    output      logic                   o_store_full
);

    logic                           tri_valid, tri_ready;
    t_tri_ctl                       tri_ctl;
    logic [2:0][COORD_WIDTH-1:0]    tri_x, tri_y;
    logic [2:0][COORD_WIDTH:0]      tri_dz;

    pssc_front #(
        .CW (COORD_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_new_mesh  (i_new_mesh),
        .i_x         ({i_vertex_c_x, i_vertex_b_x, i_vertex_a_x}),
        .i_y         ({i_vertex_c_y, i_vertex_b_y, i_vertex_a_y}),
        .i_z         ({i_vertex_c_z, i_vertex_b_z, i_vertex_a_z}),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (tri_valid),
        .i_ready     (tri_ready),
        .o_ctl       (tri_ctl),
        .o_x         (tri_x),
        .o_y         (tri_y),
        .o_dz        (tri_dz)
    );

    pssc_back #(
        .CW    (COORD_WIDTH),
        .DEPTH (SEGMENT_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (tri_valid),
        .o_ready       (tri_ready),
        .i_ctl         (tri_ctl),
        .i_x           (tri_x),
        .i_y           (tri_y),
        .i_dz          (tri_dz),
        .empty         (empty),
        .pop           (pop),
        .o_cross_x     (o_cross_x),
        .o_cross_y     (o_cross_y),
        .o_last_of_run (o_last_of_run),
        .o_store_full  (o_store_full)
    );

endmodule

`default_nettype wire

[rtl/pssc_checker.sv]
// ----------------------------------------------------------------------------
// pssc_checker
// Port-level checks on the top level, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module pssc_checker #(
    parameter int CW = 32
) (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          full,
    input wire logic          empty,
    input wire logic          pop,
    input wire logic [CW-1:0] o_cross_x,
    input wire logic [CW-1:0] o_cross_y
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input queue full after reset");

    a_hold_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result beat withdrawn");

    a_hold_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> ($stable(o_cross_x) && $stable(o_cross_y)))
        else $error("waiting result beat changed");

endmodule

bind plane_slice_segment_crossings_unit pssc_checker #(
    .CW (COORD_WIDTH)
) u_pssc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .o_cross_x (o_cross_x),
    .o_cross_y (o_cross_y)
);

`default_nettype wire
